// ===== hw/rtl/gehu_pkg.sv =====
// ============================================================================
// gehu_pkg - shared types and constants of the gear estimator
// Field widths, register reset values, state and register index codes, and
// the control word of the bit-serial accumulators.
// ============================================================================
package gehu_pkg;

    // Field widths
    localparam int SPD_W     = 16;   // speed, Q8 km/h
    localparam int RPM_W     = 14;   // engine rpm
    localparam int NOW_W     = 32;   // millisecond timestamp
    localparam int GEAR_W    = 3;
    localparam int THR_W     = 12;   // Q4 ratio registers
    localparam int CONF_W    = 16;   // confirm time register
    localparam int HYST_W    = 9;    // hysteresis permille register
    localparam int CFG_W     = 16;   // widest register
    localparam int CFG_IDX_W = 3;

    localparam int NUM_THR = 4;
    localparam int NUM_CMP = NUM_THR + 1;   // four thresholds plus the minimum ratio

    // Product widths
    localparam int LHS_SH  = 12;                 // rpm * 4096
    localparam int LHS_W   = RPM_W + LHS_SH;
    localparam int PROD_W  = THR_W + SPD_W;      // threshold * speed
    localparam int MARG_W  = 11;                 // 1000 +/- permille, up to 1511
    localparam int HPROD_W = PROD_W + MARG_W;    // threshold * speed * margin
    localparam int LM_W    = RPM_W + 10;         // rpm * 1000
    localparam int CNT_W   = 4;                  // step counter, holds SPD_W - 1

    localparam logic [SPD_W-1:0]  MIN_SPEED_Q8 = 16'd1280;   // 5 km/h
    localparam logic [RPM_W-1:0]  MIN_RPM      = 14'd500;
    localparam logic [MARG_W-1:0] PERMILLE     = 11'd1000;

    // Register reset values
    localparam logic [THR_W-1:0]  RST_THR1 = 12'd1584;
    localparam logic [THR_W-1:0]  RST_THR2 = 12'd960;
    localparam logic [THR_W-1:0]  RST_THR3 = 12'd656;
    localparam logic [THR_W-1:0]  RST_THR4 = 12'd544;
    localparam logic [THR_W-1:0]  RST_MINR = 12'd320;
    localparam logic [CONF_W-1:0] RST_CONF = 16'd700;
    localparam logic [HYST_W-1:0] RST_HYST = 9'd50;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SEL,
        S_HYS,
        S_DONE
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR1 = 3'd0,
        CFG_THR2 = 3'd1,
        CFG_THR3 = 3'd2,
        CFG_THR4 = 3'd3,
        CFG_MINR = 3'd4,
        CFG_CONF = 3'd5,
        CFG_HYST = 3'd6
    } t_cfg_idx;

    // Control word of one shift-and-add accumulator
    typedef struct packed {
        logic clr;     // zero the sum
        logic step;    // shift the sum and add the operand if din is set
        logic din;     // current multiplier bit, MSB first
    } t_acc_ctl;

endpackage

// ===== hw/rtl/gehu_acc.sv =====
// ============================================================================
// gehu_acc - bit-serial shift-and-add multiplier
// Takes one multiplier bit per cycle while step is set, MSB first; after as many
// steps as the multiplier has bits the sum holds operand times multiplier.
// ============================================================================
module gehu_acc
    import gehu_pkg::*;
#(
    parameter int WA = THR_W,
    parameter int WP = PROD_W
) (
    input  logic          i_clk,
    input  t_acc_ctl      i_ctl,
    input  logic [WA-1:0] i_a,
    output logic [WP-1:0] o_p
);

    logic [WP-1:0] r_p;
    logic [WP-1:0] n_p;

    always_comb begin
        n_p = r_p;
        if (i_ctl.clr) begin
            n_p = '0;
        end else if (i_ctl.step) begin
            n_p = {r_p[WP-2:0], 1'b0} + (i_ctl.din ? WP'(i_a) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/gear_estimate_with_hysteresis_unit.sv =====
// ============================================================================
// gear_estimate_with_hysteresis_unit - gear estimate from rpm/speed ratio
// Sequence: an input word is loaded in S_IDLE, its speed bits enter the products
//   MSB first in S_MUL, the threshold is picked in S_SEL, the margin bits enter
//   in S_HYS and S_DONE commits the result once the output register is free.
// One word at a time: the next input word is taken once the previous result
//   sits in the output register.
// Reset (synchronous, active low): default registers, gear state cleared.
// ============================================================================
module gear_estimate_with_hysteresis_unit
    import gehu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,   // speed_q8[15:0], engine_rpm[29:16],
                                                  // now_ms[61:30], zero pad
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // gear[2:0], zero pad
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  r_thr [NUM_THR];
    logic [THR_W-1:0]  r_minr;
    logic [CONF_W-1:0] r_conf_ms;
    logic [HYST_W-1:0] r_hyst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0]  <= RST_THR1;
            r_thr[1]  <= RST_THR2;
            r_thr[2]  <= RST_THR3;
            r_thr[3]  <= RST_THR4;
            r_minr    <= RST_MINR;
            r_conf_ms <= RST_CONF;
            r_hyst    <= RST_HYST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THR1, CFG_THR2, CFG_THR3, CFG_THR4: begin
                    r_thr[i_cfg_idx[1:0]] <= i_cfg_data[THR_W-1:0];
                end
                CFG_MINR: r_minr    <= i_cfg_data[THR_W-1:0];
                CFG_CONF: r_conf_ms <= i_cfg_data[CONF_W-1:0];
                CFG_HYST: r_hyst    <= i_cfg_data[HYST_W-1:0];
                default: ;   // drop writes to unknown indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;
    logic             w_commit;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        s_axis_tready = 1'b0;
        w_commit      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                n_cnt         = '0;
                if (s_axis_tvalid) begin
                    n_state = S_MUL;
                end
            end
            // one speed bit per cycle into all five products
            S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SPD_W - 1)) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                n_cnt   = '0;
                n_state = S_HYS;
            end
            // one margin bit and one bit of 1000 per cycle into the hysteresis products
            S_HYS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MARG_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            // hold until the output register is free
            S_DONE: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Input word latch
    // ------------------------------------------------------------------
    logic [SPD_W-1:0] r_spd;    // shifts out MSB first during S_MUL
    logic [RPM_W-1:0] r_rpm;
    logic [NOW_W-1:0] r_now;
    logic             r_slow;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_spd  <= s_axis_tdata[SPD_W-1:0];
            r_rpm  <= s_axis_tdata[SPD_W +: RPM_W];
            r_now  <= s_axis_tdata[SPD_W+RPM_W +: NOW_W];
            r_slow <= (s_axis_tdata[SPD_W-1:0] < MIN_SPEED_Q8) ||
                      (s_axis_tdata[SPD_W +: RPM_W] < MIN_RPM);
        end else if (r_state == S_MUL) begin
            r_spd <= {r_spd[SPD_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Threshold * speed products: thresholds 1..4 and the minimum ratio
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  w_cmp_op [NUM_CMP];
    logic [PROD_W-1:0] w_prod   [NUM_CMP];
    t_acc_ctl          w_mul_ctl;

    assign w_mul_ctl = '{clr: (r_state == S_IDLE), step: (r_state == S_MUL),
                         din: r_spd[SPD_W-1]};

    for (genvar k = 0; k < NUM_CMP; k++) begin : g_prod
        if (k < NUM_THR) begin : g_thr
            assign w_cmp_op[k] = r_thr[k];
        end else begin : g_min
            assign w_cmp_op[k] = r_minr;
        end
        gehu_acc #(
            .WA (THR_W),
            .WP (PROD_W)
        ) u_prod (
            .i_clk (i_clk),
            .i_ctl (w_mul_ctl),
            .i_a   (w_cmp_op[k]),
            .o_p   (w_prod[k])
        );
    end

    // ------------------------------------------------------------------
    // Raw gear and shift direction
    // ------------------------------------------------------------------
    logic [GEAR_W-1:0] r_cur_gear;   // confirmed gear
    logic [GEAR_W-1:0] r_cand_gear;
    logic [NOW_W-1:0]  r_since;

    logic [PROD_W-1:0] w_lhs;
    logic [GEAR_W-1:0] w_raw;
    logic              w_up, w_dn;
    logic [1:0]        w_idx;

    logic [GEAR_W-1:0] r_raw;
    logic              r_bad, r_up, r_dn;
    logic [PROD_W-1:0] r_psel;
    logic [MARG_W-1:0] r_marg;       // margin multiplier, MSB first
    logic [MARG_W-1:0] r_kbits;      // constant 1000, MSB first

    assign w_lhs = PROD_W'({r_rpm, {LHS_SH{1'b0}}});

    always_comb begin
        priority if (w_lhs > w_prod[0]) w_raw = GEAR_W'(1);
        else if (w_lhs > w_prod[1])     w_raw = GEAR_W'(2);
        else if (w_lhs > w_prod[2])     w_raw = GEAR_W'(3);
        else if (w_lhs > w_prod[3])     w_raw = GEAR_W'(4);
        else                            w_raw = GEAR_W'(5);
    end

    assign w_up  = (r_cur_gear != '0) && (w_raw > r_cur_gear);
    assign w_dn  = (r_cur_gear != '0) && (w_raw < r_cur_gear);
    // upshift tests the threshold below the raw gear, downshift its own
    assign w_idx = w_up ? 2'(w_raw - GEAR_W'(2)) : 2'(w_raw - GEAR_W'(1));

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEL) begin
            r_raw   <= w_raw;
            r_bad   <= r_slow || (w_lhs < w_prod[NUM_CMP-1]);
            r_up    <= w_up;
            r_dn    <= w_dn;
            r_psel  <= w_prod[w_idx];
            r_marg  <= w_up ? (PERMILLE - MARG_W'(r_hyst)) : (PERMILLE + MARG_W'(r_hyst));
            r_kbits <= PERMILLE;
        end else if (r_state == S_HYS) begin
            r_marg  <= {r_marg[MARG_W-2:0], 1'b0};
            r_kbits <= {r_kbits[MARG_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Hysteresis products: threshold*speed*margin and rpm*1000
    // ------------------------------------------------------------------
    t_acc_ctl           w_hq_ctl, w_lm_ctl;
    logic [HPROD_W-1:0] w_hq;
    logic [LM_W-1:0]    w_lm;

    assign w_hq_ctl = '{clr: (r_state == S_SEL), step: (r_state == S_HYS),
                        din: r_marg[MARG_W-1]};
    assign w_lm_ctl = '{clr: (r_state == S_SEL), step: (r_state == S_HYS),
                        din: r_kbits[MARG_W-1]};

    gehu_acc #(
        .WA (PROD_W),
        .WP (HPROD_W)
    ) u_hq (
        .i_clk (i_clk),
        .i_ctl (w_hq_ctl),
        .i_a   (r_psel),
        .o_p   (w_hq)
    );

    gehu_acc #(
        .WA (RPM_W),
        .WP (LM_W)
    ) u_lm (
        .i_clk (i_clk),
        .i_ctl (w_lm_ctl),
        .i_a   (r_rpm),
        .o_p   (w_lm)
    );

    // ------------------------------------------------------------------
    // Commit: proposal, candidate timing, confirmed gear
    // ------------------------------------------------------------------
    logic [HPROD_W-1:0] w_lhsm;
    logic [NOW_W-1:0]   w_elapsed;
    logic [GEAR_W-1:0]  w_prop;
    logic [GEAR_W-1:0]  n_cur_gear, n_cand_gear;
    logic [NOW_W-1:0]   n_since;

    assign w_lhsm    = HPROD_W'({w_lm, {LHS_SH{1'b0}}});
    assign w_elapsed = r_now - r_since;

    always_comb begin
        w_prop = r_cur_gear;
        if (r_cur_gear == '0) begin
            w_prop = r_raw;
        end else if (r_up && (w_lhsm < w_hq)) begin
            w_prop = r_raw;
        end else if (r_dn && (w_lhsm > w_hq)) begin
            w_prop = r_raw;
        end
    end

    always_comb begin
        n_cur_gear  = r_cur_gear;
        n_cand_gear = r_cand_gear;
        n_since     = r_since;
        priority if (r_bad) begin
            // too slow, idle or ratio below the valid range: clear all
            n_cur_gear  = '0;
            n_cand_gear = '0;
            n_since     = '0;
        end else if (w_prop == r_cur_gear) begin
            n_cand_gear = '0;
            n_since     = '0;
        end else if (r_cand_gear != w_prop) begin
            // new candidate: start its timer
            n_cand_gear = w_prop;
            n_since     = r_now;
        end else if (w_elapsed >= NOW_W'(r_conf_ms)) begin
            n_cur_gear  = w_prop;
            n_cand_gear = '0;
            n_since     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_gear  <= '0;
            r_cand_gear <= '0;
            r_since     <= '0;
        end else if (w_commit) begin
            r_cur_gear  <= n_cur_gear;
            r_cand_gear <= n_cand_gear;
            r_since     <= n_since;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic              r_ovalid;
    logic [GEAR_W-1:0] r_ogear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_commit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_ogear <= n_cur_gear;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = 8'(r_ogear);

endmodule

// ===== hw/rtl/gehu_chk.sv =====
// ============================================================================
// gehu_chk - port checker of the gear estimator
// Watches the top level's ports and flags handshake and result slips.
// ============================================================================
module gehu_chk
    import gehu_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [7:0]           m_axis_tdata
);

    // gear stays in 0..5 with a clean pad
    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd5) && (m_axis_tdata[7:3] == 5'd0))
        else $error("gear out of range");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");

    // one word at a time: input closes after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input open while a word is in work");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind gear_estimate_with_hysteresis_unit gehu_chk u_gehu_chk (.*);
